@@ rtl/chbi_pkg.sv @@
`default_nettype none

package chbi_pkg;

  localparam int BUCKET_BITS  = 12;
  localparam int BUCKET_COUNT = 1 << BUCKET_BITS;
  localparam int POOL_ENTRIES = 1024;
  localparam int POOL_BITS    = $clog2(POOL_ENTRIES);
  localparam int ACTION_W     = 2;
  localparam int KEY_W        = 32;
  localparam int HANDLE_W     = 10;
  localparam int LINK_W       = HANDLE_W + 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FOLLOW = 2'd3;

  typedef logic [ACTION_W-1:0]    action_t;
  typedef logic [BUCKET_BITS-1:0] bucket_t;
  typedef logic [HANDLE_W-1:0]    handle_t;
  typedef logic [LINK_W-1:0]      link_t;
  typedef logic [POOL_BITS-1:0]   link_addr_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    action_t action;
    bucket_t bucket;
    handle_t handle;
    logic    in_pool;
  } req_t;

  function automatic logic handle_in_pool(handle_t h);
    return 32'(h) < 32'(POOL_ENTRIES);
  endfunction

  function automatic link_addr_t link_addr(handle_t h);
    return link_addr_t'(h);
  endfunction

endpackage

`default_nettype wire

@@ rtl/chained_hash_bucket_index.sv @@
`default_nettype none

// Hash bucket index with chained entries. A request is taken at a clock edge where start is
// high and busy is low; it waits in a two-deep queue, so start may be taken while an earlier
// request is still running. Each request gives exactly one result, shown for one cycle with
// done high; the receiver cannot hold it off. For insert, lookup, follow and a remove at the
// head of its bucket, the back end reads the head and link memories, then does the update and
// result; it returns to idle before it takes the next request from the queue. Remove of a
// handle that is not at the head of its bucket walks its chain one link at a time, at most one
// step per pool entry, because the link memory has a single read port. After reset, busy stays
// high while the bucket head table is cleared one entry per cycle.
module chained_hash_bucket_index (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] key,
  input  wire logic [9:0]  handle,
  output logic             done,
  output logic             status,
  output logic [9:0]       result_handle
);

  import chbi_pkg::*;

  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  logic clearing;
  req_t push_req;
  req_t queue_req;

  chbi_front u_front (
    .start      (start),
    .action     (action),
    .key        (key),
    .handle     (handle),
    .queue_full (queue_full),
    .clearing   (clearing),
    .busy       (busy),
    .push       (push),
    .req        (push_req)
  );

  chbi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head_req (queue_req)
  );

  chbi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .queue_req     (queue_req),
    .pop           (pop),
    .clearing      (clearing),
    .done          (done),
    .status        (status),
    .result_handle (result_handle)
  );

endmodule

`default_nettype wire

@@ rtl/chbi_ram.sv @@
`default_nettype none

module chbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/chbi_front.sv @@
`default_nettype none

module chbi_front (
  input  wire logic              start,
  input  wire logic [1:0]        action,
  input  wire logic [31:0]       key,
  input  wire logic [9:0]        handle,
  input  wire logic              queue_full,
  input  wire logic              clearing,
  output logic                   busy,
  output logic                   push,
  output chbi_pkg::req_t         req
);

  import chbi_pkg::*;

  assign busy = queue_full | clearing;
  assign push = start & ~busy;

  // Only the low key bits select a bucket; the pool check is done once here.
  always_comb begin
    req.action  = action_t'(action);
    req.bucket  = key[BUCKET_BITS-1:0];
    req.handle  = handle_t'(handle);
    req.in_pool = handle_in_pool(handle_t'(handle));
  end

endmodule

`default_nettype wire

@@ rtl/chbi_queue.sv @@
`default_nettype none

module chbi_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire chbi_pkg::req_t push_req,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output chbi_pkg::req_t      head_req
);

  import chbi_pkg::*;

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign head_req = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

`default_nettype wire

@@ rtl/chbi_back.sv @@
`default_nettype none

module chbi_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           queue_empty,
  input  wire chbi_pkg::req_t queue_req,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output logic                status,
  output logic [9:0]          result_handle
);

  import chbi_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_WALK  = 2'd3;

  logic [1:0]     state, state_next;
  bucket_t        clr_cnt;
  req_t           cur, cur_next;
  handle_t        prev, prev_next;
  link_t          hlink, hlink_next;
  link_addr_t     steps, steps_next;
  logic           done_next, status_next;
  handle_t        result_next;

  logic           head_we;
  bucket_t        head_waddr;
  link_t          head_wdata;
  link_t          head_rdata;
  logic           link_we;
  link_addr_t     link_waddr;
  link_t          link_wdata;
  link_addr_t     link_raddr;
  link_t          link_rdata;

  handle_t        head_h;
  handle_t        link_h;
  logic           head_ok;
  logic           link_ok;

  chbi_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_COUNT)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (queue_req.bucket),
    .rdata (head_rdata)
  );

  chbi_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign head_h   = head_rdata[HANDLE_W-1:0];
  assign link_h   = link_rdata[HANDLE_W-1:0];
  assign head_ok  = head_rdata[LINK_W-1];
  assign link_ok  = link_rdata[LINK_W-1];
  assign clearing = state == S_CLEAR;
  assign pop      = (state == S_IDLE) && !queue_empty;

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    prev_next   = prev;
    hlink_next  = hlink;
    steps_next  = steps;
    done_next   = 1'b0;
    status_next = status;
    result_next = result_handle;
    head_we     = 1'b0;
    head_waddr  = cur.bucket;
    head_wdata  = '0;
    link_we     = 1'b0;
    link_waddr  = link_addr(prev);
    link_wdata  = hlink;
    link_raddr  = link_addr(queue_req.handle);

    unique case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt;
        if (&clr_cnt) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // Both the bucket head and the request's own link are read here.
        if (pop) begin
          cur_next   = queue_req;
          state_next = S_READ;
        end
      end
      S_READ: begin
        link_raddr  = link_addr(head_h);
        done_next   = 1'b1;
        state_next  = S_IDLE;
        result_next = cur.handle;
        case (cur.action)
          ACT_INSERT: begin
            status_next = !cur.in_pool;
            if (cur.in_pool) begin
              link_we    = 1'b1;
              link_waddr = link_addr(cur.handle);
              link_wdata = head_rdata;
              head_we    = 1'b1;
              head_wdata = {1'b1, cur.handle};
            end
          end
          ACT_LOOKUP: begin
            status_next = !head_ok;
            result_next = head_ok ? head_h : '0;
          end
          ACT_FOLLOW: begin
            status_next = !(cur.in_pool && link_ok);
            result_next = (cur.in_pool && link_ok) ? link_h : '0;
          end
          default: begin
            status_next = 1'b1;
            if (cur.in_pool && head_ok) begin
              if (head_h == cur.handle) begin
                head_we     = 1'b1;
                head_wdata  = link_rdata;
                status_next = 1'b0;
              end else if (handle_in_pool(head_h)) begin
                // Not the head: walk the chain, one link read per cycle.
                done_next  = 1'b0;
                state_next = S_WALK;
                prev_next  = head_h;
                hlink_next = link_rdata;
                steps_next = '0;
              end
            end
          end
        endcase
      end
      S_WALK: begin
        link_raddr  = link_addr(link_h);
        result_next = cur.handle;
        status_next = 1'b1;
        done_next   = 1'b1;
        state_next  = S_IDLE;
        if (link_ok) begin
          if (link_h == cur.handle) begin
            link_we     = 1'b1;
            status_next = 1'b0;
          end else if (steps != link_addr_t'(POOL_ENTRIES - 1) && handle_in_pool(link_h)) begin
            done_next  = 1'b0;
            state_next = S_WALK;
            prev_next  = link_h;
            steps_next = steps + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur           <= cur_next;
    prev          <= prev_next;
    hlink         <= hlink_next;
    steps         <= steps_next;
    status        <= status_next;
    result_handle <= result_next;
  end

  // The back end passes through idle between any two results, so results never touch.
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results in consecutive cycles");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("request taken while the head table is being cleared");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!head_we && !link_we))
    else $error("table written while no request is in progress");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_READ || $past(state) == S_WALK))
    else $error("result without a request being processed");

endmodule

`default_nettype wire

@@ tb/sv/tb_chained_hash_bucket_index.sv @@
`timescale 1ns / 100ps

module tb_chained_hash_bucket_index;
  import chbi_pkg::*;

  localparam int RANDOM_REQUESTS = 1676;
  localparam int QUIET_TAIL      = 250;
  localparam int HOT_COUNT       = 12;
  localparam int STALL_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int DIR_ROWS        = 24;
  // Bucket kept out of the hot set; it carries the self-linked chain.
  localparam bucket_t LOOP_BUCKET = 12'h5A5;

  typedef enum int {PICK_FREE, PICK_LINKED, PICK_WRITTEN} pick_kind_t;

  typedef struct packed {
    logic    st;
    handle_t rh;
  } bucket_result_t;

  typedef struct packed {
    action_t     act;
    logic [31:0] key;
    handle_t     hdl;
    logic        typed;
    logic        st;
    handle_t     rh;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  action_t     action;
  logic [31:0] key;
  handle_t     handle;
  logic        done;
  logic        status;
  handle_t     result_handle;

  link_t   head_table [BUCKET_COUNT];
  link_t   next_table [POOL_ENTRIES];
  bit      ever_linked [POOL_ENTRIES];
  bit      in_chain [POOL_ENTRIES];
  bucket_t home_bucket [POOL_ENTRIES];
  bucket_t hot_buckets [HOT_COUNT];

  bucket_result_t pending_results [$];
  bucket_result_t want;
  int error_count;
  int results_checked;
  int not_found_count;
  int action_count [4];
  int stall_cycles;

  // Rows with typed = 1 carry a result that follows directly from the table contents.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ACT_LOOKUP, 32'h0000_0000, 10'd0,    1'b1, 1'b1, 10'd0},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 10'd0,    1'b1, 1'b1, 10'd0},
    '{ACT_REMOVE, 32'h0000_0000, 10'd0,    1'b1, 1'b1, 10'd0},
    '{ACT_INSERT, 32'h0000_0000, 10'd0,    1'b1, 1'b0, 10'd0},
    '{ACT_INSERT, 32'hFFFF_F000, 10'd1023, 1'b1, 1'b0, 10'd1023},
    '{ACT_LOOKUP, 32'h1234_5000, 10'd0,    1'b1, 1'b0, 10'd1023},
    '{ACT_FOLLOW, 32'h0000_0000, 10'd1023, 1'b1, 1'b0, 10'd0},
    '{ACT_FOLLOW, 32'h0000_0000, 10'd0,    1'b1, 1'b1, 10'd0},
    '{ACT_INSERT, 32'hFFFF_FFFF, 10'd512,  1'b1, 1'b0, 10'd512},
    '{ACT_INSERT, 32'h0000_0000, 10'd341,  1'b1, 1'b0, 10'd341},
    '{ACT_REMOVE, 32'hABCD_E000, 10'd1023, 1'b1, 1'b0, 10'd1023},
    '{ACT_FOLLOW, 32'h0000_0000, 10'd341,  1'b0, 1'b0, 10'd0},
    '{ACT_REMOVE, 32'h0000_0000, 10'd700,  1'b1, 1'b1, 10'd700},
    '{ACT_REMOVE, 32'hFFFF_FFFF, 10'd512,  1'b1, 1'b0, 10'd512},
    '{ACT_LOOKUP, 32'h7FFF_FFFF, 10'd0,    1'b1, 1'b1, 10'd0},
    '{ACT_FOLLOW, 32'h0000_0000, 10'd1023, 1'b0, 1'b0, 10'd0},
    '{ACT_LOOKUP, 32'h0000_0000, 10'd0,    1'b0, 1'b0, 10'd0},
    '{ACT_INSERT, 32'h0000_05A5, 10'd682,  1'b1, 1'b0, 10'd682},
    '{ACT_INSERT, 32'h8000_05A5, 10'd682,  1'b1, 1'b0, 10'd682},
    '{ACT_REMOVE, 32'h0000_05A5, 10'd700,  1'b1, 1'b1, 10'd700},
    '{ACT_FOLLOW, 32'h0000_0000, 10'd682,  1'b0, 1'b0, 10'd0},
    '{ACT_REMOVE, 32'h0000_05A5, 10'd682,  1'b1, 1'b0, 10'd682},
    '{ACT_LOOKUP, 32'h5555_55A5, 10'd0,    1'b0, 1'b0, 10'd0},
    '{ACT_LOOKUP, 32'hAAAA_AABC, 10'd0,    1'b0, 1'b0, 10'd0}
  };

  chained_hash_bucket_index u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .key           (key),
    .handle        (handle),
    .done          (done),
    .status        (status),
    .result_handle (result_handle)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to the shadow tables and returns the result it must produce.
  function automatic bucket_result_t bucket_index_predict(action_t a, logic [31:0] k,
                                                          handle_t h);
    bucket_result_t r;
    bucket_t bkt;
    link_t   cur;
    link_t   nxt;
    handle_t prev;
    bit      in_pool;
    bit      searching;
    int      hops;
    bkt     = k[BUCKET_BITS-1:0];
    in_pool = 32'(h) < 32'(POOL_ENTRIES);
    r.st    = 1'b1;
    r.rh    = '0;
    case (a)
      ACT_INSERT: begin
        r.rh = h;
        if (in_pool) begin
          next_table[h]   = head_table[bkt];
          head_table[bkt] = {1'b1, h};
          r.st = 1'b0;
        end
      end
      ACT_LOOKUP: begin
        cur = head_table[bkt];
        if (cur[HANDLE_W]) begin
          r.st = 1'b0;
          r.rh = cur[HANDLE_W-1:0];
        end
      end
      ACT_REMOVE: begin
        r.rh = h;
        cur  = head_table[bkt];
        if (in_pool && cur[HANDLE_W]) begin
          if (cur[HANDLE_W-1:0] == h) begin
            head_table[bkt] = next_table[h];
            r.st = 1'b0;
          end else begin
            // Walk the chain; a cycle left by a double insert ends the walk after one
            // step per pool entry.
            prev      = cur[HANDLE_W-1:0];
            searching = 1'b1;
            hops      = 0;
            while (searching && hops < POOL_ENTRIES) begin
              nxt = next_table[prev];
              if (!nxt[HANDLE_W]) begin
                searching = 1'b0;
              end else if (nxt[HANDLE_W-1:0] == h) begin
                next_table[prev] = next_table[h];
                r.st = 1'b0;
                searching = 1'b0;
              end else begin
                prev = nxt[HANDLE_W-1:0];
              end
              hops++;
            end
          end
        end
      end
      default: begin
        if (in_pool) begin
          nxt = next_table[h];
          if (nxt[HANDLE_W]) begin
            r.st = 1'b0;
            r.rh = nxt[HANDLE_W-1:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] key_in_bucket(bucket_t b);
    logic [31:0] r;
    r = $urandom();
    return {r[31:BUCKET_BITS], b};
  endfunction

  function automatic bucket_t pick_bucket(int pct_hot);
    if ($urandom_range(0, 99) < pct_hot) return hot_buckets[$urandom_range(0, HOT_COUNT-1)];
    return bucket_t'($urandom());
  endfunction

  // Random tries first, then a scan from a random start; a random handle on failure.
  function automatic bit pick_handle(pick_kind_t kind, output handle_t h);
    handle_t cand;
    int      base;
    bit      ok;
    ok   = 1'b0;
    h    = handle_t'($urandom());
    base = $urandom_range(0, POOL_ENTRIES-1);
    for (int i = 0; i < 32 + POOL_ENTRIES && !ok; i++) begin
      if (i < 32) cand = handle_t'($urandom());
      else cand = handle_t'((base + i) % POOL_ENTRIES);
      case (kind)
        PICK_FREE:   ok = !in_chain[cand];
        PICK_LINKED: ok = in_chain[cand];
        default:     ok = ever_linked[cand];
      endcase
      if (ok) h = cand;
    end
    return ok;
  endfunction

  task automatic make_random_request(output action_t a, output logic [31:0] k,
                                     output handle_t h);
    int      roll;
    bucket_t b;
    roll = $urandom_range(0, 99);
    h    = handle_t'($urandom());
    b    = pick_bucket(90);
    a    = ACT_LOOKUP;
    if (roll < 35) begin
      a = ACT_INSERT;
      // Now and then the handle is left random, which may link it a second time.
      if ($urandom_range(0, 99) != 0) void'(pick_handle(PICK_FREE, h));
    end else if (roll < 55) begin
      a = ACT_LOOKUP;
    end else if (roll < 80) begin
      a    = ACT_REMOVE;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        if (pick_handle(PICK_LINKED, h)) b = home_bucket[h];
      end else if (roll >= 85) begin
        b = bucket_t'($urandom());
      end
    end else begin
      a = ACT_FOLLOW;
      // Only handles whose link has been written may be followed.
      if (!pick_handle(PICK_WRITTEN, h)) a = ACT_LOOKUP;
    end
    k = key_in_bucket(b);
  endtask

  task automatic issue_request(action_t a, logic [31:0] k, handle_t h, logic typed,
                               bucket_result_t typed_res, bit allow_gap);
    bucket_result_t r;
    int gap;
    gap = 0;
    if (allow_gap && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    action <= a;
    key    <= k;
    handle <= h;
    do @(posedge clk); while (busy);
    r = bucket_index_predict(a, k, h);
    pending_results.push_back(typed ? typed_res : r);
    action_count[a]++;
    if (a == ACT_INSERT && !r.st) begin
      ever_linked[h] = 1'b1;
      in_chain[h]    = 1'b1;
      home_bucket[h] = k[BUCKET_BITS-1:0];
    end
    if (a == ACT_REMOVE && !r.st) in_chain[h] = 1'b0;
  endtask

  task automatic report_mismatch(string what, int got, int want_val);
    error_count++;
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want_val);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, result_handle", result_handle, -1);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.st) not_found_count++;
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (result_handle !== want.rh) report_mismatch("result_handle", result_handle, want.rh);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t timeout with %0d results pending", $realtime, pending_results.size());
        $display("[chained_hash_bucket_index] ERROR");
        $finish;
      end
    end
  end

  initial begin
    action_t     a;
    logic [31:0] k;
    handle_t     h;
    rst             = 1'b1;
    start           = 1'b0;
    action          = ACT_INSERT;
    key             = '0;
    handle          = '0;
    error_count     = 0;
    results_checked = 0;
    not_found_count = 0;
    stall_cycles    = 0;
    for (int i = 0; i < 4; i++) action_count[i] = 0;
    for (int i = 0; i < BUCKET_COUNT; i++) head_table[i] = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      next_table[i]  = '0;
      ever_linked[i] = 1'b0;
      in_chain[i]    = 1'b0;
      home_bucket[i] = '0;
    end
    hot_buckets[0] = '0;
    hot_buckets[1] = bucket_t'(BUCKET_COUNT - 1);
    for (int i = 2; i < HOT_COUNT; i++) begin
      do hot_buckets[i] = bucket_t'($urandom()); while (hot_buckets[i] == LOOP_BUCKET);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      issue_request(dir_rows[i].act, dir_rows[i].key, dir_rows[i].hdl, dir_rows[i].typed,
                    '{st: dir_rows[i].st, rh: dir_rows[i].rh}, 1'b0);
    end
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      make_random_request(a, k, h);
      issue_request(a, k, h, 1'b0, '0, n < RANDOM_REQUESTS - QUIET_TAIL);
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d insert, %0d lookup, %0d remove, %0d follow over %0d hot buckets",
             action_count[ACT_INSERT], action_count[ACT_LOOKUP], action_count[ACT_REMOVE],
             action_count[ACT_FOLLOW], HOT_COUNT);
    $display("results checked: %0d, of which %0d reported empty or not found, %0d mismatches",
             results_checked, not_found_count, error_count);
    if (error_count == 0) begin
      $display("[chained_hash_bucket_index] OK");
    end else begin
      $display("[chained_hash_bucket_index] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/chbi_pkg.sv
rtl/chbi_ram.sv
rtl/chbi_front.sv
rtl/chbi_queue.sv
rtl/chbi_back.sv
rtl/chained_hash_bucket_index.sv
tb/sv/tb_chained_hash_bucket_index.sv
